[rtl/positional_list_engine_core_defines.svh]
// assertion macros used by positional_list_engine_core
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ple_pkg.sv]
`default_nettype none
package ple_pkg;

  localparam int DEPTH_DEF = 256;

  localparam int OPCODE_W   = 3;
  localparam int POSITION_W = 9;
  localparam int VALUE_W    = 32;
  localparam int SUM_W      = 40;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 9;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SUM    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

[rtl/ple_ram.sv]
`default_nettype none
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/positional_list_engine_core.sv]
// append, rejected and unknown requests go from decode straight to the result; read waits
// for the ram read, and insert, remove and sum walk the entries first; a finished result
// waits in S_DONE while the result side holds off
// one request is in flight at a time; the entry walk through the registered-read ram moves
// one entry per cycle
// reset (synchronous, active high) empties the list; ram contents are not cleared
`default_nettype none
module positional_list_engine_core #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // request side
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // opcode [2:0], position [11:3], value_in [43:12], zero fill [47:44]
  input  wire logic [ple_pkg::IN_TDATA_W-1:0]     s_tdata,
  // result side
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // value_out [39:0], status [41:40], count [50:42], zero fill [55:51]
  output logic      [ple_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  import ple_pkg::*;

`include "positional_list_engine_core_defines.svh"

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_READW  = 3'd2;
  localparam logic [2:0] S_INS    = 3'd3;
  localparam logic [2:0] S_REM    = 3'd4;
  localparam logic [2:0] S_SUM    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]            state;

  // latched request
  logic [OPCODE_W-1:0]   op;
  logic [POSITION_W-1:0] pos;
  logic [VALUE_W-1:0]    val;

  // list length, walk index and the one-deep read pipeline of the walk
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic                  pend;
  logic [AW-1:0]         pend_addr;

  // shared accumulator: holds the read value or the running sum
  logic [SUM_W-1:0]      acc;
  logic [STATUS_W-1:0]   res_status;

  // decode of the latched request: status and where the sequencer goes next
  logic [STATUS_W-1:0]   dec_status;
  logic [2:0]            dec_state;

  // result register
  logic [SUM_W-1:0]      out_value;
  logic [STATUS_W-1:0]   out_status;
  logic [COUNT_W-1:0]    out_count;

  // ram port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_W-1:0]    ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_W-1:0]    ram_rdata;

  // compare views, all zero-extended to a common width
  logic [CMPW-1:0]       pos_x;
  logic [CMPW-1:0]       cnt_x;
  logic [CMPW-1:0]       idx_x;
  logic                  full;
  logic                  idx_below_cnt;
  logic [SUM_W-1:0]      rdata_sx;

  assign pos_x         = CMPW'(pos);
  assign cnt_x         = CMPW'(count);
  assign idx_x         = CMPW'(idx);
  assign full          = (cnt_x == CMPW'(DEPTH));
  assign idx_below_cnt = (idx < count);
  assign rdata_sx      = {{(SUM_W-VALUE_W){ram_rdata[VALUE_W-1]}}, ram_rdata};

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(OUT_TDATA_W-SUM_W-STATUS_W-COUNT_W){1'b0}},
                     out_count, out_status, out_value};

  ple_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // range check comes before the full check on insert
  always_comb begin
    dec_status = ST_OK;
    dec_state  = S_DONE;
    unique case (op)
      OP_APPEND: begin
        if (full) begin
          dec_status = ST_FULL;
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_state = S_INS;
        end
      end
      OP_READ, OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          dec_status = ST_RANGE;
        end else begin
          dec_state = S_READW;
        end
      end
      OP_SUM: begin
        dec_state = S_SUM;
      end
      default: begin
      end
    endcase
  end

  // ram control: one read and at most one write per cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = val;
    ram_raddr = '0;
    unique case (state)
      S_DECIDE: begin
        if (op == OP_APPEND && !full) begin
          ram_we    = 1'b1;
          ram_waddr = count[AW-1:0];
        end
        ram_raddr = AW'(pos);
      end
      S_INS: begin
        // shift toward the tail, highest entry first
        if (idx_x > pos_x) begin
          ram_raddr = AW'(idx - 1'b1);
        end
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr;
          ram_wdata = ram_rdata;
        end else if (idx_x == pos_x) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pos);
        end
      end
      S_REM: begin
        // close the gap, lowest entry first
        if (idx_below_cnt) begin
          ram_raddr = AW'(idx);
        end
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr;
          ram_wdata = ram_rdata;
        end
      end
      S_SUM: begin
        if (idx_below_cnt) begin
          ram_raddr = AW'(idx);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // result register loads once the previous result has left
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tdata[OPCODE_W-1:0];
            pos   <= s_tdata[OPCODE_W +: POSITION_W];
            val   <= s_tdata[OPCODE_W+POSITION_W +: VALUE_W];
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          acc        <= '0;
          res_status <= dec_status;
          idx        <= (dec_state == S_INS) ? count : '0;
          pend       <= 1'b0;
          state      <= dec_state;
          if (op == OP_APPEND && !full) begin
            count <= count + 1'b1;
          end
        end
        S_READW: begin
          acc <= rdata_sx;
          if (op == OP_REMOVE) begin
            idx   <= CW'(pos) + 1'b1;
            state <= S_REM;
          end else begin
            state <= S_DONE;
          end
        end
        S_INS: begin
          if (idx_x > pos_x) begin
            pend      <= 1'b1;
            pend_addr <= idx[AW-1:0];
            idx       <= idx - 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count <= count + 1'b1;
            state <= S_DONE;
          end
        end
        S_REM: begin
          if (idx_below_cnt) begin
            pend      <= 1'b1;
            pend_addr <= AW'(idx - 1'b1);
            idx       <= idx + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_SUM: begin
          if (pend) begin
            acc <= acc + rdata_sx;
          end
          if (idx_below_cnt) begin
            pend <= 1'b1;
            idx  <= idx + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded together with m_tvalid
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      out_value  <= acc;
      out_status <= res_status;
      out_count  <= COUNT_W'(count);
    end
  end

  `PLE_ASSERT_IMP(a_count_bound, 1'b1, CMPW'(count) <= CMPW'(DEPTH),
                  "list length above depth")
  `PLE_ASSERT_IMP(a_err_no_value, m_tvalid && out_status != ST_OK, out_value == '0,
                  "failed request carries a value")
  `PLE_ASSERT_NXT(a_accept_decide, s_tvalid && s_tready, state == S_DECIDE,
                  "accepted request not decoded next cycle")
  `PLE_ASSERT_NXT(a_count_step, 1'b1,
                  count == $past(count) || count == $past(count) + 1'b1 ||
                  count == $past(count) - 1'b1,
                  "list length moved by more than one")
  `PLE_ASSERT_IMP(a_pend_walk, pend,
                  state == S_INS || state == S_REM || state == S_SUM,
                  "walk pipeline busy outside a walk")

endmodule
`default_nettype wire

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int LIST_DEPTH      = DEPTH_DEF;
  localparam int IDLE_PCT        = 14;
  localparam int HOLD_OFF_CYCLES = 400;
  // longest walk through the list plus a margin
  localparam int DRAIN_CYCLES    = LIST_DEPTH + 32;
  localparam int CYCLE_LIMIT     = 3_000_000;

  // opcodes the block must ignore
  localparam logic [OPCODE_W-1:0] OP_SPARE_5 = OP_SUM + 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = OP_SUM + 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = OP_SUM + 3'd3;

  typedef enum int {MIX_OPS, GROW_LIST, SHRINK_LIST} traffic_mix_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;
  } list_result_t;

  // shadow copy of the list plus the queue of results still owed by the block
  class list_tracker;
    logic signed [VALUE_W-1:0] shadow_list[$];
    list_result_t              owed_results[$];
    int                        errors = 0;

    function int length();
      return shadow_list.size();
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    // applies one request to the shadow list and returns what the block must answer
    function list_result_t apply_request(logic [OPCODE_W-1:0] op, logic [POSITION_W-1:0] pos,
                                         logic signed [VALUE_W-1:0] val);
      list_result_t res;
      int n;
      int p;
      res.value  = '0;
      res.status = ST_OK;
      n = shadow_list.size();
      p = int'(pos);
      case (op)
        OP_APPEND: begin
          if (n >= LIST_DEPTH) res.status = ST_FULL;
          else shadow_list.push_back(val);
        end
        OP_INSERT: begin
          // range check wins over the full check
          if (p > n) res.status = ST_RANGE;
          else if (n >= LIST_DEPTH) res.status = ST_FULL;
          else shadow_list.insert(p, val);
        end
        OP_READ: begin
          if (p >= n) res.status = ST_RANGE;
          else res.value = SUM_W'(shadow_list[p]);
        end
        OP_REMOVE: begin
          if (p >= n) res.status = ST_RANGE;
          else begin
            res.value = SUM_W'(shadow_list[p]);
            shadow_list.delete(p);
          end
        end
        OP_SUM: begin
          foreach (shadow_list[i]) res.value = res.value + SUM_W'(shadow_list[i]);
        end
        default: ;
      endcase
      res.count = COUNT_W'(shadow_list.size());
      return res;
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, logic [POSITION_W-1:0] pos,
                               logic signed [VALUE_W-1:0] val);
      owed_results.push_back(apply_request(op, pos, val));
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      list_result_t want;
      list_result_t got;
      got.value  = word[39:0];
      got.status = word[41:40];
      got.count  = word[50:42];
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual value %0d status %0d count %0d",
                 $time, got.value, got.status, got.count);
        return;
      end
      want = owed_results.pop_front();
      if (got.value !== want.value) report("value_out", want.value, got.value);
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.count !== want.count) report("count", want.count, got.count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // opcode [2:0], position [11:3], value_in [43:12], zero fill [47:44]
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // value_out [39:0], status [41:40], count [50:42], zero fill [55:51]
  logic [OUT_TDATA_W-1:0] m_tdata;

  list_tracker tracker = new;

  // both sides stop idling while this is set
  bit no_idle = 1'b0;
  // bumped by the stimulus each time the result side should hold off
  int hold_off_asked = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  positional_list_engine_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** positional_list_engine_core: FAILED **");
      $finish;
    end
  end

  // result side: checks each accepted result and drives tready with random stalls
  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
      if (holds_served != hold_off_asked) begin
        holds_served = hold_off_asked;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (no_idle) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // offers one request and returns right after the edge that accepts it
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [POSITION_W-1:0] pos,
                              input logic [VALUE_W-1:0] val);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, val, pos, op};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(op, pos, val);
  endtask

  // stops offering until every owed result has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  function automatic logic [OPCODE_W-1:0] pick_op(traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      GROW_LIST: begin
        if (r < 40) return OP_APPEND;
        if (r < 75) return OP_INSERT;
        if (r < 83) return OP_READ;
        if (r < 93) return OP_REMOVE;
        if (r < 97) return OP_SUM;
      end
      SHRINK_LIST: begin
        if (r < 8) return OP_APPEND;
        if (r < 15) return OP_INSERT;
        if (r < 30) return OP_READ;
        if (r < 92) return OP_REMOVE;
        if (r < 97) return OP_SUM;
      end
      default: begin
        if (r < 25) return OP_APPEND;
        if (r < 50) return OP_INSERT;
        if (r < 70) return OP_READ;
        if (r < 90) return OP_REMOVE;
        if (r < 97) return OP_SUM;
      end
    endcase
    case ($urandom_range(0, 2))
      0:       return OP_SPARE_5;
      1:       return OP_SPARE_6;
      default: return OP_SPARE_7;
    endcase
  endfunction

  // mostly valid positions, with the edges and the odd wild one
  function automatic logic [POSITION_W-1:0] pick_position(logic [OPCODE_W-1:0] op);
    int n;
    int r;
    n = tracker.length();
    r = $urandom_range(0, 99);
    if (r < 10) return POSITION_W'($urandom_range(0, 511));
    if (r < 20) return POSITION_W'(n);
    if (r < 28) return '0;
    if (op == OP_INSERT) return POSITION_W'($urandom_range(0, n));
    return (n == 0) ? '0 : POSITION_W'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(int extreme_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < extreme_pct / 2) return 32'h7fff_ffff;
    if (r < extreme_pct) return 32'h8000_0000;
    if (r < extreme_pct + 4) return 32'h0;
    if (r < extreme_pct + 8) return 32'hffff_ffff;
    return $urandom();
  endfunction

  task automatic send_random(input traffic_mix_t mix);
    logic [OPCODE_W-1:0] op;
    op = pick_op(mix);
    send_request(op, pick_position(op), pick_value((mix == GROW_LIST) ? 30 : 10));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: sum is zero, read and remove at any position and insert past the end are out of range
    send_request(OP_SUM, 9'd0, 32'h0);
    send_request(OP_READ, 9'd0, 32'h0);
    send_request(OP_REMOVE, 9'd0, 32'h0);
    send_request(OP_INSERT, 9'd1, 32'h1234_5678);
    // insert at the head of an empty list, then at the tail and in the middle
    send_request(OP_INSERT, 9'd0, 32'h8000_0000);
    send_request(OP_APPEND, 9'h1ff, 32'h7fff_ffff);
    send_request(OP_INSERT, 9'd2, 32'hffff_ffff);
    send_request(OP_INSERT, 9'd1, 32'h0);
    // reads at both ends and just past them
    send_request(OP_READ, 9'd0, 32'h0);
    send_request(OP_READ, 9'd3, 32'h0);
    send_request(OP_READ, 9'd4, 32'h0);
    send_request(OP_READ, 9'h1ff, 32'hffff_ffff);
    send_request(OP_SUM, 9'd0, 32'h0);
    // spare opcodes leave the list alone
    send_request(OP_SPARE_5, 9'h1ff, 32'hffff_ffff);
    send_request(OP_SPARE_6, 9'd0, 32'h0);
    send_request(OP_SPARE_7, 9'd2, 32'h8000_0000);
    send_request(OP_INSERT, 9'h1ff, 32'h5555_5555);
    // remove the tail, then the head, then past the new end
    send_request(OP_REMOVE, 9'd3, 32'h0);
    send_request(OP_REMOVE, 9'd0, 32'h0);
    send_request(OP_REMOVE, 9'd2, 32'h0);
    send_request(OP_SUM, 9'd0, 32'h0);
    send_request(OP_APPEND, 9'd0, 32'haaaa_aaaa);
    wait_for_results();

    // general mix
    repeat (250) send_random(MIX_OPS);
    wait_for_results();

    // fill up the list while the result side holds off for a while
    hold_off_asked++;
    while (tracker.length() < LIST_DEPTH) send_random(GROW_LIST);
    // full list: range check before the full check, then the full cases
    send_request(OP_INSERT, 9'(LIST_DEPTH + 1), 32'h0);
    send_request(OP_INSERT, 9'd0, 32'h1);
    send_request(OP_INSERT, 9'(LIST_DEPTH), 32'h2);
    send_request(OP_APPEND, 9'd0, 32'h3);
    send_request(OP_SUM, 9'd0, 32'h0);
    send_request(OP_READ, 9'(LIST_DEPTH - 1), 32'h0);
    repeat (60) send_random(GROW_LIST);
    wait_for_results();

    // drain the list down to empty and keep poking at it
    while (tracker.length() > 0) send_random(SHRINK_LIST);
    repeat (30) send_random(SHRINK_LIST);
    wait_for_results();

    // back-to-back stretch with no idling on either side, then the usual mix
    no_idle = 1'b1;
    repeat (100) send_random(MIX_OPS);
    no_idle = 1'b0;
    repeat (100) send_random(MIX_OPS);

    wait_for_results();
    // give a stray extra result time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("** positional_list_engine_core: PASSED **");
    else $display("** positional_list_engine_core: FAILED **");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_ram.sv
rtl/positional_list_engine_core.sv
tb/tb.sv
